[hw/rtl/igl_pkg.sv]
// Shared types and constants for the integer ALU with GCD and LCM.
package igl_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    typedef enum logic [2:0] {
        FN_ADD = 3'd0,
        FN_SUB = 3'd1,
        FN_MUL = 3'd2,
        FN_DIV = 3'd3,
        FN_MOD = 3'd4,
        FN_GCD = 3'd5,
        FN_LCM = 3'd6,
        FN_BAD = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DIV0  = 2'd1,
        ST_BADOP = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ARITH,
        S_MAG_A,
        S_MAG_B,
        S_DIV,
        S_GCD,
        S_MUL,
        S_NEG,
        S_DONE
    } state_t;

    typedef struct packed {
        func_t                  func;
        logic signed [DATA_WIDTH-1:0] operand_a;
        logic signed [DATA_WIDTH-1:0] operand_b;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] result;
        logic [1:0]                   status;
    } rsp_t;

endpackage

[hw/rtl/igl_addsub.sv]
// Shared add/subtract unit, one bit wider than the data path for borrow out.
module igl_addsub
    import igl_pkg::*;
(
    input  logic [DATA_WIDTH:0] op_x,
    input  logic [DATA_WIDTH:0] op_y,
    input  logic                sub,
    output logic [DATA_WIDTH:0] sum
);

    always_comb
    begin
        if (sub)
        begin
            sum = op_x - op_y;
        end
        else
        begin
            sum = op_x + op_y;
        end
    end

endmodule

[hw/rtl/integer_alu_with_gcd_lcm.sv]
// Top level: sequencer and registers of the integer ALU with GCD and LCM.
//
// Usage:
//   Drive cmd (func, operand_a, operand_b) and raise start. The word is
//   taken at a rising edge with start high and busy low. busy stays high
//   until the result word has been shown. The result word (result, status)
//   is marked valid on rsp by done for exactly one cycle; the receiver cannot
//   hold it off and must take it then.
// Operations, all on one shared adder:
//   add, sub:            one add or subtract of a and b
//   invalid code:        no arithmetic, status ST_BADOP
//   mul (shift-add):     low DATA_WIDTH bits of the product
//   div, mod (restoring): on |a| and |b|, then a sign fix-up step when needed
//   div, mod by zero:    no divide, status ST_DIV0
//   gcd (binary, one shift, subtract-and-shift or swap per cycle) of |a| and
//       |b|; the time depends on the operands
//   lcm: gcd, then divide |a| by g, then multiply by |b|
// One word is in flight at a time; the next start is taken the cycle after
// done. Reset clears the sequencer to idle; no result is pending after it.
module integer_alu_with_gcd_lcm
    import igl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  cmd_t cmd,
    output logic busy,
    output logic done,
    output rsp_t rsp
);

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

    // control state
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // payload
    func_t                 func_reg, func_next;
    logic                  a_neg_reg, a_neg_next;
    logic                  b_neg_reg, b_neg_next;
    logic [DATA_WIDTH-1:0] x_reg, x_next;    // operand A / multiplicand / gcd x
    logic [DATA_WIDTH-1:0] y_reg, y_next;    // operand B / divisor / gcd y
    logic [DATA_WIDTH-1:0] q_reg, q_next;    // dividend-quotient / multiplier
    logic [DATA_WIDTH-1:0] r_reg, r_next;    // partial remainder / product
    logic [DATA_WIDTH-1:0] mb_reg, mb_next;  // |b| kept for lcm
    logic [CNT_W-1:0]      k_reg, k_next;    // common factors of two in gcd
    logic [DATA_WIDTH-1:0] res_reg, res_next;
    status_t               stat_reg, stat_next;

    // shared unit
    logic [DATA_WIDTH:0] op_x, op_y, sum;
    logic                op_sub;

    logic                  borrow;
    logic                  x_zero, y_zero, cnt_last, gcd_found, need_neg;
    logic [DATA_WIDTH-1:0] g_val;
    logic [DATA_WIDTH-1:0] div_q, div_r;

    igl_addsub u_addsub (
        .op_x (op_x),
        .op_y (op_y),
        .sub  (op_sub),
        .sum  (sum)
    );

    assign borrow    = sum[DATA_WIDTH];
    assign x_zero    = (x_reg == '0);
    assign y_zero    = (y_reg == '0);
    assign cnt_last  = (cnt_reg == CNT_LAST);
    assign gcd_found = x_zero || y_zero;
    assign g_val     = (x_zero ? y_reg : x_reg) << k_reg;
    assign need_neg  = (func_reg == FN_DIV) ? (a_neg_reg ^ b_neg_reg) : a_neg_reg;

    // one restoring-division step
    always_comb
    begin
        if (!borrow)
        begin
            div_r = sum[DATA_WIDTH-1:0];
            div_q = {q_reg[DATA_WIDTH-2:0], 1'b1};
        end
        else
        begin
            div_r = {r_reg[DATA_WIDTH-2:0], q_reg[DATA_WIDTH-1]};
            div_q = {q_reg[DATA_WIDTH-2:0], 1'b0};
        end
    end

    // operand select for the shared unit
    always_comb
    begin
        op_x   = '0;
        op_y   = '0;
        op_sub = 1'b0;
        unique case (state_reg)
            S_ARITH:
            begin
                op_x   = {1'b0, x_reg};
                op_y   = {1'b0, y_reg};
                op_sub = (func_reg == FN_SUB);
            end
            S_MAG_A:
            begin
                op_y   = {1'b0, x_reg};
                op_sub = 1'b1;
            end
            S_MAG_B:
            begin
                op_y   = {1'b0, y_reg};
                op_sub = 1'b1;
            end
            S_DIV:
            begin
                op_x   = {r_reg, q_reg[DATA_WIDTH-1]};
                op_y   = {1'b0, y_reg};
                op_sub = 1'b1;
            end
            S_GCD:
            begin
                op_x   = {1'b0, x_reg};
                op_y   = {1'b0, y_reg};
                op_sub = 1'b1;
            end
            S_MUL:
            begin
                op_x = {1'b0, r_reg};
                op_y = q_reg[0] ? {1'b0, x_reg} : '0;
            end
            S_NEG:
            begin
                op_y   = {1'b0, res_reg};
                op_sub = 1'b1;
            end
            default:
            begin
                op_sub = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd.func)
                        FN_ADD, FN_SUB: state_next = S_ARITH;
                        FN_MUL:         state_next = S_MUL;
                        FN_BAD:         state_next = S_DONE;
                        default:        state_next = S_MAG_A;
                    endcase
                end
            end
            S_ARITH: state_next = S_DONE;
            S_MAG_A: state_next = S_MAG_B;
            S_MAG_B:
            begin
                if (func_reg == FN_GCD || func_reg == FN_LCM)
                begin
                    state_next = S_GCD;
                end
                else if (y_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (cnt_last)
                begin
                    priority if (func_reg == FN_LCM)
                    begin
                        state_next = S_MUL;
                    end
                    else if (need_neg)
                    begin
                        state_next = S_NEG;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_GCD:
            begin
                if (gcd_found)
                begin
                    if (func_reg == FN_GCD || g_val == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_MUL:
            begin
                if (cnt_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_NEG:   state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath next values
    always_comb
    begin
        cnt_next   = cnt_reg;
        func_next  = func_reg;
        a_neg_next = a_neg_reg;
        b_neg_next = b_neg_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        mb_next    = mb_reg;
        k_next     = k_reg;
        res_next   = res_reg;
        stat_next  = stat_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    func_next  = cmd.func;
                    x_next     = cmd.operand_a;
                    y_next     = cmd.operand_b;
                    a_neg_next = cmd.operand_a[DATA_WIDTH-1];
                    b_neg_next = cmd.operand_b[DATA_WIDTH-1];
                    q_next     = cmd.operand_b;
                    r_next     = '0;
                    cnt_next   = '0;
                    k_next     = '0;
                    res_next   = '0;
                    stat_next  = (cmd.func == FN_BAD) ? ST_BADOP : ST_OK;
                end
            end
            S_ARITH:
            begin
                res_next = sum[DATA_WIDTH-1:0];
            end
            S_MAG_A:
            begin
                if (a_neg_reg)
                begin
                    x_next = sum[DATA_WIDTH-1:0];
                end
            end
            S_MAG_B:
            begin
                y_next   = b_neg_reg ? sum[DATA_WIDTH-1:0] : y_reg;
                mb_next  = b_neg_reg ? sum[DATA_WIDTH-1:0] : y_reg;
                q_next   = x_reg;
                r_next   = '0;
                cnt_next = '0;
                k_next   = '0;
                if ((func_reg == FN_DIV || func_reg == FN_MOD) && y_zero)
                begin
                    stat_next = ST_DIV0;
                end
            end
            S_DIV:
            begin
                q_next   = div_q;
                r_next   = div_r;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    cnt_next = '0;
                    if (func_reg == FN_LCM)
                    begin
                        // |a|/g times |b|
                        x_next = div_q;
                        q_next = mb_reg;
                        r_next = '0;
                    end
                    else if (func_reg == FN_DIV)
                    begin
                        res_next = div_q;
                    end
                    else
                    begin
                        res_next = div_r;
                    end
                end
            end
            S_GCD:
            begin
                priority if (gcd_found)
                begin
                    res_next = g_val;
                    y_next   = g_val;
                    r_next   = '0;
                    cnt_next = '0;
                end
                else if (!x_reg[0] && !y_reg[0])
                begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
                else if (!x_reg[0])
                begin
                    x_next = x_reg >> 1;
                end
                else if (!y_reg[0])
                begin
                    y_next = y_reg >> 1;
                end
                else if (!borrow)
                begin
                    x_next = {1'b0, sum[DATA_WIDTH-1:1]};
                end
                else
                begin
                    x_next = y_reg;
                    y_next = x_reg;
                end
            end
            S_MUL:
            begin
                if (q_reg[0])
                begin
                    r_next = sum[DATA_WIDTH-1:0];
                end
                x_next   = x_reg << 1;
                q_next   = q_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    cnt_next = '0;
                    res_next = q_reg[0] ? sum[DATA_WIDTH-1:0] : r_reg;
                end
            end
            S_NEG:
            begin
                res_next = sum[DATA_WIDTH-1:0];
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        a_neg_reg <= a_neg_next;
        b_neg_reg <= b_neg_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        q_reg     <= q_next;
        r_reg     <= r_next;
        mb_reg    <= mb_next;
        k_reg     <= k_next;
        res_reg   <= res_next;
        stat_reg  <= stat_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = (state_reg == S_DONE);
    assign rsp.result = res_reg;
    assign rsp.status = stat_reg;

endmodule
